// File: src/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Types, widths and register indexes shared by the quaternion rotate block.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned M1_W       = 2 * DATA_W;
    localparam int unsigned P_W        = M1_W + 1;
    localparam int unsigned M2_W       = P_W + DATA_W;
    localparam int unsigned R_W        = M2_W + 2;
    localparam int unsigned FRAC_SHIFT = 28;
    localparam int unsigned N_PROD     = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_W = CFG_IDX_W'(3);

    localparam logic signed [DATA_W-1:0] ROT_W_RESET = DATA_W'(16384);

    typedef struct packed {
        logic signed [DATA_W-1:0] vin_x;
        logic signed [DATA_W-1:0] vin_y;
        logic signed [DATA_W-1:0] vin_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] vout_x;
        logic signed [DATA_W-1:0] vout_y;
        logic signed [DATA_W-1:0] vout_z;
        logic                     clipped;
    } t_vec_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
        logic signed [DATA_W-1:0] rot_w;
    } t_quat;

    typedef struct packed {
        logic signed [P_W-1:0] px;
        logic signed [P_W-1:0] py;
        logic signed [P_W-1:0] pz;
        logic signed [P_W-1:0] ps;
    } t_pquat;

    typedef struct packed {
        logic signed [R_W-1:0] rx;
        logic signed [R_W-1:0] ry;
        logic signed [R_W-1:0] rz;
    } t_rvec;

endpackage

// File: src/qvr_stream_if.sv
// ----------------------------------------------------------------------------
// qvr_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface qvr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: src/qvr_cfg_regs.sv
// ----------------------------------------------------------------------------
// qvr_cfg_regs
// Quaternion register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module qvr_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qvr_pkg::t_cfg_wr i_wr,
    output qvr_pkg::t_quat   o_quat
);
    import qvr_pkg::*;

    t_quat r_quat;
    t_quat n_quat;

    assign o_ready = 1'b1;
    assign o_quat  = r_quat;

    always_comb begin
        n_quat = r_quat;
        if (i_valid) begin
            unique case (i_wr.index)
                REG_ROT_X: n_quat.rot_x = i_wr.value;
                REG_ROT_Y: n_quat.rot_y = i_wr.value;
                REG_ROT_Z: n_quat.rot_z = i_wr.value;
                REG_ROT_W: n_quat.rot_w = i_wr.value;
                default:   n_quat = r_quat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.rot_x <= '0;
            r_quat.rot_y <= '0;
            r_quat.rot_z <= '0;
            r_quat.rot_w <= ROT_W_RESET;
        end else begin
            r_quat <= n_quat;
        end
    end
endmodule

// File: src/qvr_qv_mul.sv
// ----------------------------------------------------------------------------
// qvr_qv_mul
// First product p = q * (v, 0): a multiply stage, then a sum stage.
// ----------------------------------------------------------------------------
module qvr_qv_mul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qvr_pkg::t_vec_in i_vec,
    input  qvr_pkg::t_quat   i_quat,
    output logic             o_valid,
    input  logic             i_ready,
    output qvr_pkg::t_pquat  o_pq
);
    import qvr_pkg::*;

    logic                   r_v1;
    logic                   r_v2;
    logic signed [M1_W-1:0] r_m [N_PROD];
    logic signed [M1_W-1:0] n_m [N_PROD];
    t_pquat                 r_pq;
    t_pquat                 n_pq;
    logic                   w_adv1;
    logic                   w_adv2;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;
    assign o_pq    = r_pq;

    always_comb begin
        n_m[0]  = M1_W'(i_quat.rot_w) * M1_W'(i_vec.vin_x);
        n_m[1]  = M1_W'(i_quat.rot_y) * M1_W'(i_vec.vin_z);
        n_m[2]  = M1_W'(i_quat.rot_z) * M1_W'(i_vec.vin_y);
        n_m[3]  = M1_W'(i_quat.rot_w) * M1_W'(i_vec.vin_y);
        n_m[4]  = M1_W'(i_quat.rot_z) * M1_W'(i_vec.vin_x);
        n_m[5]  = M1_W'(i_quat.rot_x) * M1_W'(i_vec.vin_z);
        n_m[6]  = M1_W'(i_quat.rot_w) * M1_W'(i_vec.vin_z);
        n_m[7]  = M1_W'(i_quat.rot_x) * M1_W'(i_vec.vin_y);
        n_m[8]  = M1_W'(i_quat.rot_y) * M1_W'(i_vec.vin_x);
        n_m[9]  = M1_W'(i_quat.rot_x) * M1_W'(i_vec.vin_x);
        n_m[10] = M1_W'(i_quat.rot_y) * M1_W'(i_vec.vin_y);
        n_m[11] = M1_W'(i_quat.rot_z) * M1_W'(i_vec.vin_z);
    end

    always_comb begin
        n_pq.px = P_W'(r_m[0]) + P_W'(r_m[1]) - P_W'(r_m[2]);
        n_pq.py = P_W'(r_m[3]) + P_W'(r_m[4]) - P_W'(r_m[5]);
        n_pq.pz = P_W'(r_m[6]) + P_W'(r_m[7]) - P_W'(r_m[8]);
        n_pq.ps = P_W'(0) - P_W'(r_m[9]) - P_W'(r_m[10]) - P_W'(r_m[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_m <= n_m;
        end
        if (w_adv2 && r_v1) begin
            r_pq <= n_pq;
        end
    end
endmodule

// File: src/qvr_qc_mul.sv
// ----------------------------------------------------------------------------
// qvr_qc_mul
// Vector part of p * conj(q): a multiply stage, then a sum stage.
// ----------------------------------------------------------------------------
module qvr_qc_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_pquat i_pq,
    input  qvr_pkg::t_quat  i_quat,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_rvec  o_r
);
    import qvr_pkg::*;

    logic                   r_v1;
    logic                   r_v2;
    logic signed [M2_W-1:0] r_m [N_PROD];
    logic signed [M2_W-1:0] n_m [N_PROD];
    t_rvec                  r_r;
    t_rvec                  n_r;
    logic                   w_adv1;
    logic                   w_adv2;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;
    assign o_r     = r_r;

    always_comb begin
        n_m[0]  = M2_W'(i_pq.ps) * M2_W'(i_quat.rot_x);
        n_m[1]  = M2_W'(i_pq.px) * M2_W'(i_quat.rot_w);
        n_m[2]  = M2_W'(i_pq.py) * M2_W'(i_quat.rot_z);
        n_m[3]  = M2_W'(i_pq.pz) * M2_W'(i_quat.rot_y);
        n_m[4]  = M2_W'(i_pq.ps) * M2_W'(i_quat.rot_y);
        n_m[5]  = M2_W'(i_pq.py) * M2_W'(i_quat.rot_w);
        n_m[6]  = M2_W'(i_pq.pz) * M2_W'(i_quat.rot_x);
        n_m[7]  = M2_W'(i_pq.px) * M2_W'(i_quat.rot_z);
        n_m[8]  = M2_W'(i_pq.ps) * M2_W'(i_quat.rot_z);
        n_m[9]  = M2_W'(i_pq.pz) * M2_W'(i_quat.rot_w);
        n_m[10] = M2_W'(i_pq.px) * M2_W'(i_quat.rot_y);
        n_m[11] = M2_W'(i_pq.py) * M2_W'(i_quat.rot_x);
    end

    always_comb begin
        n_r.rx = R_W'(r_m[1]) - R_W'(r_m[0]) - R_W'(r_m[2]) + R_W'(r_m[3]);
        n_r.ry = R_W'(r_m[5]) - R_W'(r_m[4]) - R_W'(r_m[6]) + R_W'(r_m[7]);
        n_r.rz = R_W'(r_m[9]) - R_W'(r_m[8]) - R_W'(r_m[10]) + R_W'(r_m[11]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_valid) begin
            r_m <= n_m;
        end
        if (w_adv2 && r_v1) begin
            r_r <= n_r;
        end
    end
endmodule

// File: src/qvr_round_sat.sv
// ----------------------------------------------------------------------------
// qvr_round_sat
// Output stage: round half up to Q8.8, saturate, flag any clipping.
// ----------------------------------------------------------------------------
module qvr_round_sat (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qvr_pkg::t_rvec    i_r,
    output logic              o_valid,
    input  logic              i_ready,
    output qvr_pkg::t_vec_out o_vec
);
    import qvr_pkg::*;

    localparam int unsigned Q_W = R_W - FRAC_SHIFT;
    localparam logic signed [R_W-1:0] ROUND_HALF =
        {{(R_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);

    function automatic logic [DATA_W:0] f_round_sat(input logic signed [R_W-1:0] s);
        logic signed [R_W-1:0] t;
        logic signed [Q_W-1:0] q;
        logic [DATA_W:0]       res;
        t = s + ROUND_HALF;
        q = t[R_W-1:FRAC_SHIFT];
        if (q > SAT_MAX) begin
            res = {1'b1, SAT_MAX[DATA_W-1:0]};
        end else if (q < SAT_MIN) begin
            res = {1'b1, SAT_MIN[DATA_W-1:0]};
        end else begin
            res = {1'b0, q[DATA_W-1:0]};
        end
        return res;
    endfunction

    logic            r_v;
    t_vec_out        r_vec;
    t_vec_out        n_vec;
    logic [DATA_W:0] w_sx;
    logic [DATA_W:0] w_sy;
    logic [DATA_W:0] w_sz;
    logic            w_adv;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v;
    assign o_vec   = r_vec;

    always_comb begin
        w_sx          = f_round_sat(i_r.rx);
        w_sy          = f_round_sat(i_r.ry);
        w_sz          = f_round_sat(i_r.rz);
        n_vec.vout_x  = w_sx[DATA_W-1:0];
        n_vec.vout_y  = w_sy[DATA_W-1:0];
        n_vec.vout_z  = w_sz[DATA_W-1:0];
        n_vec.clipped = w_sx[DATA_W] | w_sy[DATA_W] | w_sz[DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_vec <= n_vec;
        end
    end
endmodule

// File: src/quaternion_vector_rotate.sv
// Rotates each Q8.8 input vector by the configured Q2.14 quaternion as
// q * v * conj(q), using the quaternion exactly as written (a non-unit
// quaternion also scales by |q|^2). The datapath is five register stages:
// the q*v products, their sums, the products with conj(q), their sums,
// and the round/saturate output register. One vector is accepted every
// cycle while the output is not stalled. Each stage holds under
// back-pressure and keeps taking items while it has a free slot. Write
// the quaternion only while no vectors are in flight; the configuration
// channel is always ready.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Top level: configuration registers and the five-stage rotate pipeline.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qvr_stream_if.sink   i_cfg,
    qvr_stream_if.sink   i_vin,
    qvr_stream_if.source o_vout
);
    import qvr_pkg::*;

    t_quat    w_quat;
    t_pquat   w_pq;
    t_rvec    w_r;
    logic     w_pq_valid;
    logic     w_pq_ready;
    logic     w_r_valid;
    logic     w_r_ready;
    logic     w_cfg_ready;
    logic     w_vin_ready;
    logic     w_out_valid;
    t_vec_out w_out;

    assign i_cfg.ready  = w_cfg_ready;
    assign i_vin.ready  = w_vin_ready;
    assign o_vout.valid = w_out_valid;
    assign o_vout.data  = w_out;

    qvr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (w_cfg_ready),
        .i_wr    (i_cfg.data),
        .o_quat  (w_quat)
    );

    qvr_qv_mul u_qv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vin.valid),
        .o_ready (w_vin_ready),
        .i_vec   (i_vin.data),
        .i_quat  (w_quat),
        .o_valid (w_pq_valid),
        .i_ready (w_pq_ready),
        .o_pq    (w_pq)
    );

    qvr_qc_mul u_qc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pq_valid),
        .o_ready (w_pq_ready),
        .i_pq    (w_pq),
        .i_quat  (w_quat),
        .o_valid (w_r_valid),
        .i_ready (w_r_ready),
        .o_r     (w_r)
    );

    qvr_round_sat u_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r_valid),
        .o_ready (w_r_ready),
        .i_r     (w_r),
        .o_valid (w_out_valid),
        .i_ready (o_vout.ready),
        .o_vec   (w_out)
    );

`ifndef SYNTH
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_out_valid)
        else $error("output valid right after reset");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_valid && w_out.clipped |->
            (w_out.vout_x == 16'h7fff || w_out.vout_x == 16'h8000 ||
             w_out.vout_y == 16'h7fff || w_out.vout_y == 16'h8000 ||
             w_out.vout_z == 16'h7fff || w_out.vout_z == 16'h8000))
        else $error("clip flag set without a saturated component");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_r_valid && !w_r_ready |=> w_r_valid && $stable(w_r))
        else $error("sum stage lost or changed a stalled item");
`endif
endmodule

// File: bench/quaternion_vector_rotate_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_tb
// Self-checking bench for the quaternion vector rotate pipeline. A scoreboard
// class predicts q * v * conj(q) with exact 64-bit integer math, rounding half
// up and saturating, and checks every output transfer in order. The stimulus
// begins with directed corner vectors, a quarter turn, rounding ties and
// saturation. It then sweeps several quaternion settings with random vectors,
// random gaps on both sides, and one long output stall.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_tb;
    import qvr_pkg::*;

    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned RANDOM_PHASES = 7;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned IDLE_PCT      = 20;
    localparam int unsigned HOLD_AT       = 200;
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned QUIET_FROM    = 350;
    localparam int unsigned QUIET_TO      = 500;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    localparam int Q_ONE   = 16384;
    localparam int Q_HALF  = 8192;
    localparam int Q_COS45 = 11585;
    localparam int Q_MIN   = -32768;

    localparam longint SAT_MAX = 32767;
    localparam longint SAT_MIN = -32768;

    class rotation_scoreboard;
        t_quat    rot;
        t_vec_out expected_rotations[$];
        int       errors;
        int       checked;
        int       clip_count;

        function new();
            rot        = '{rot_x: '0, rot_y: '0, rot_z: '0, rot_w: ROT_W_RESET};
            errors     = 0;
            checked    = 0;
            clip_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ROT_X: rot.rot_x = value;
                REG_ROT_Y: rot.rot_y = value;
                REG_ROT_Z: rot.rot_z = value;
                REG_ROT_W: rot.rot_w = value;
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] saturate(input longint sum, inout logic flag);
            longint rounded;
            rounded = (sum + (longint'(1) << (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            if (rounded > SAT_MAX) begin
                flag    = 1'b1;
                rounded = SAT_MAX;
            end else if (rounded < SAT_MIN) begin
                flag    = 1'b1;
                rounded = SAT_MIN;
            end
            return DATA_W'(rounded);
        endfunction

        function t_vec_out rotate_vector(t_vec_in v);
            longint   vx, vy, vz, qx, qy, qz, qw;
            longint   px, py, pz, ps, rx, ry, rz;
            logic     flag;
            t_vec_out r;
            vx = longint'($signed(v.vin_x));
            vy = longint'($signed(v.vin_y));
            vz = longint'($signed(v.vin_z));
            qx = longint'($signed(rot.rot_x));
            qy = longint'($signed(rot.rot_y));
            qz = longint'($signed(rot.rot_z));
            qw = longint'($signed(rot.rot_w));
            px = qw * vx + qy * vz - qz * vy;
            py = qw * vy + qz * vx - qx * vz;
            pz = qw * vz + qx * vy - qy * vx;
            ps = -qx * vx - qy * vy - qz * vz;
            rx = -ps * qx + px * qw - py * qz + pz * qy;
            ry = -ps * qy + py * qw - pz * qx + px * qz;
            rz = -ps * qz + pz * qw - px * qy + py * qx;
            flag       = 1'b0;
            r.vout_x   = saturate(rx, flag);
            r.vout_y   = saturate(ry, flag);
            r.vout_z   = saturate(rz, flag);
            r.clipped  = flag;
            return r;
        endfunction

        function void note_vector(t_vec_in v);
            expected_rotations.push_back(rotate_vector(v));
        endfunction

        function int pending();
            return expected_rotations.size();
        endfunction

        function void check_result(t_vec_out got);
            t_vec_out want;
            if (expected_rotations.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d clipped=%0b",
                       $signed(got.vout_x), $signed(got.vout_y), $signed(got.vout_z),
                       got.clipped);
                errors++;
                return;
            end
            want = expected_rotations.pop_front();
            checked++;
            if (got.clipped === 1'b1) clip_count++;
            if (got.vout_x !== want.vout_x) begin
                $error("vout_x mismatch: expected %0d, got %0d",
                       $signed(want.vout_x), $signed(got.vout_x));
                errors++;
            end
            if (got.vout_y !== want.vout_y) begin
                $error("vout_y mismatch: expected %0d, got %0d",
                       $signed(want.vout_y), $signed(got.vout_y));
                errors++;
            end
            if (got.vout_z !== want.vout_z) begin
                $error("vout_z mismatch: expected %0d, got %0d",
                       $signed(want.vout_z), $signed(got.vout_z));
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped mismatch: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    qvr_stream_if #(.T(t_cfg_wr))  cfg_if  ();
    qvr_stream_if #(.T(t_vec_in))  vin_if  ();
    qvr_stream_if #(.T(t_vec_out)) vout_if ();

    quaternion_vector_rotate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_vin   (vin_if),
        .o_vout  (vout_if)
    );

    rotation_scoreboard sb;
    int unsigned        sent;
    int unsigned        settings;
    int unsigned        cycle_count;
    bit                 quiet;
    bit                 hold_req;

    int corner_vecs[12][3] = '{
        '{0, 0, 0}, '{32767, 32767, 32767}, '{-32768, -32768, -32768},
        '{1, -1, 256}, '{-1, 1, -256}, '{32767, -32768, 0},
        '{-32768, 0, 32767}, '{21845, -21846, 255}, '{-21846, 21845, -255},
        '{0, 32767, -32768}, '{256, 512, -768}, '{-12345, 6789, 30000}
    };
    int turn_vecs[4][3] = '{
        '{256, 0, 0}, '{0, 256, 0}, '{0, 0, 256}, '{32767, -32768, 12345}
    };
    int tie_vecs[3][3] = '{
        '{2, -2, 6}, '{-6, 6, -2}, '{10, -10, -14}
    };
    int clip_vecs[5][3] = '{
        '{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{256, -256, 0},
        '{100, 200, -300}, '{0, 0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vout_if.valid && vout_if.ready) sb.check_result(vout_if.data);
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        vout_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                vout_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            vout_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic t_vec_in make_vec(int x, int y, int z);
        t_vec_in v;
        v.vin_x = DATA_W'(x);
        v.vin_y = DATA_W'(y);
        v.vin_z = DATA_W'(z);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] random_field();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6) return DATA_W'($urandom);
        if (pick < 8) return DATA_W'($urandom_range(1023) - 512);
        case ($urandom_range(2))
            0: return DATA_W'(SAT_MAX);
            1: return DATA_W'(SAT_MIN);
            default: return '0;
        endcase
    endfunction

    function automatic t_vec_in random_vec();
        t_vec_in v;
        v.vin_x = random_field();
        v.vin_y = random_field();
        v.vin_z = random_field();
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] random_comp(bit full);
        if (full) return DATA_W'($urandom);
        return DATA_W'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
    endfunction

    function automatic t_quat make_quat(int x, int y, int z, int w);
        t_quat q;
        q.rot_x = DATA_W'(x);
        q.rot_y = DATA_W'(y);
        q.rot_z = DATA_W'(z);
        q.rot_w = DATA_W'(w);
        return q;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: value};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.write_register(idx, value);
    endtask

    task automatic write_quat(t_quat q, bit stray);
        cfg_write(REG_ROT_X, q.rot_x);
        cfg_write(REG_ROT_Y, q.rot_y);
        cfg_write(REG_ROT_Z, q.rot_z);
        cfg_write(REG_ROT_W, q.rot_w);
        // unmapped index must leave the quaternion alone
        if (stray || $urandom_range(1) == 1)
            cfg_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_ROT_W) + 1)),
                      DATA_W'($urandom));
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    task automatic send_vector(t_vec_in v);
        while (!quiet && !hold_req && $urandom_range(99) < IDLE_PCT) begin
            vin_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        vin_if.valid <= 1'b1;
        vin_if.data  <= v;
        @(posedge i_clk);
        while (!vin_if.ready) @(posedge i_clk);
        sb.note_vector(v);
        sent++;
        quiet = (sent >= QUIET_FROM) && (sent < QUIET_TO);
        if (sent == HOLD_AT) hold_req = 1'b1;
    endtask

    task automatic drain();
        vin_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_quat q;
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        vin_if.valid = 1'b0;
        vin_if.data  = '0;
        sent         = 0;
        settings     = 1;
        cycle_count  = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        sb           = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity quaternion out of reset
        foreach (corner_vecs[i])
            send_vector(make_vec(corner_vecs[i][0], corner_vecs[i][1], corner_vecs[i][2]));
        drain();

        // quarter turn about z
        write_quat(make_quat(0, 0, Q_COS45, Q_COS45), 1'b0);
        foreach (turn_vecs[i])
            send_vector(make_vec(turn_vecs[i][0], turn_vecs[i][1], turn_vecs[i][2]));
        drain();

        // half-scale identity puts exact halves on the rounding point
        write_quat(make_quat(0, 0, 0, Q_HALF), 1'b0);
        foreach (tie_vecs[i])
            send_vector(make_vec(tie_vecs[i][0], tie_vecs[i][1], tie_vecs[i][2]));
        drain();

        // most negative pattern everywhere: large gain, heavy saturation
        write_quat(make_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1);
        foreach (clip_vecs[i])
            send_vector(make_vec(clip_vecs[i][0], clip_vecs[i][1], clip_vecs[i][2]));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                q = make_quat(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
            else if (p == 1)
                q = make_quat(-Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
            else begin
                q.rot_x = random_comp(p == RANDOM_PHASES - 1);
                q.rot_y = random_comp(p == RANDOM_PHASES - 1);
                q.rot_z = random_comp(p == RANDOM_PHASES - 1);
                q.rot_w = random_comp(p == RANDOM_PHASES - 1);
            end
            write_quat(q, 1'b0);
            repeat (PHASE_ITEMS) send_vector(random_vec());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Rotated %0d vectors under %0d quaternion settings, %0d results checked,",
                 sent, settings, sb.checked);
        $display("%0d of them saturated, with random gaps and a long output stall.",
                 sb.clip_count);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
